@@ design/tmas_pkg.sv @@
// Shared types, widths and the rate-gain ROM for the touch motion / scroll unit.
// No dependencies; every other file in the design imports this package.
package tmas_pkg;

  localparam int unsigned COORD_W        = 16;
  localparam int unsigned PRESS_W        = 8;
  localparam int unsigned TIME_W         = 32;
  localparam int unsigned GAP_W          = 6;
  localparam int unsigned MOVE_W         = 16;
  localparam int unsigned MAX_GAP_MS     = 32;
  localparam int unsigned GAP_IDX_W      = $clog2(MAX_GAP_MS);
  localparam int unsigned GAIN_FRAC_BITS = 12;
  localparam int unsigned GAIN_W         = 31;

  localparam int unsigned APB_ADDR_W   = 3;
  localparam int unsigned APB_DATA_W   = 32;
  localparam int unsigned REG_ADDR_LSB = 2;

  localparam logic [PRESS_W-1:0] PRESSURE_LIMIT_RST = 8'd200;
  localparam logic [GAP_W-1:0]   GAP_LIMIT_RST      = 6'd20;

  typedef enum logic {
    REG_PRESSURE_LIMIT = 1'b0,
    REG_GAP_LIMIT      = 1'b1
  } reg_idx_e;

  typedef enum logic {
    KIND_MOVE   = 1'b0,
    KIND_SCROLL = 1'b1
  } report_kind_e;

  typedef struct packed {
    logic [PRESS_W-1:0] pressure_limit;
    logic [GAP_W-1:0]   gap_limit_ms;
  } cfg_t;

  typedef struct packed {
    logic               first_touch;
    logic               second_touch;
    logic [COORD_W-1:0] first_x;
    logic [COORD_W-1:0] first_y;
    logic [PRESS_W-1:0] first_pressure;
    logic [COORD_W-1:0] second_y;
    logic [PRESS_W-1:0] second_pressure;
    logic [TIME_W-1:0]  time_ms;
  } touch_item_t;

  typedef struct packed {
    logic                     valid;
    report_kind_e             kind;
    logic signed [MOVE_W-1:0] horizontal;
    logic signed [MOVE_W-1:0] vertical;
  } result_t;

  // 0.1 * 1.16^(100/dt) in Q19.12, rounded; entry 0 is never used
  function automatic logic [GAIN_W-1:0] gain_lookup(input logic [GAP_IDX_W-1:0] dt);
    logic [GAIN_W-1:0] g;
    case (dt)
      5'd1:    g = 31'd1143296467;
      5'd2:    g = 31'd684320;
      5'd3:    g = 31'd57671;
      5'd4:    g = 31'd16742;
      5'd5:    g = 31'd7971;
      5'd6:    g = 31'd4860;
      5'd7:    g = 31'd3413;
      5'd8:    g = 31'd2619;
      5'd9:    g = 31'd2131;
      5'd10:   g = 31'd1807;
      5'd11:   g = 31'd1579;
      5'd12:   g = 31'd1411;
      5'd13:   g = 31'd1283;
      5'd14:   g = 31'd1182;
      5'd15:   g = 31'd1102;
      5'd16:   g = 31'd1036;
      5'd17:   g = 31'd981;
      5'd18:   g = 31'd934;
      5'd19:   g = 31'd895;
      5'd20:   g = 31'd860;
      5'd21:   g = 31'd830;
      5'd22:   g = 31'd804;
      5'd23:   g = 31'd781;
      5'd24:   g = 31'd760;
      5'd25:   g = 31'd742;
      5'd26:   g = 31'd725;
      5'd27:   g = 31'd710;
      5'd28:   g = 31'd696;
      5'd29:   g = 31'd683;
      5'd30:   g = 31'd672;
      5'd31:   g = 31'd661;
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

@@ design/tmas_cfg_regs.sv @@
// APB-style configuration registers: pressure limit and gap limit.
// Depends on tmas_pkg.
module tmas_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tmas_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [tmas_pkg::APB_DATA_W-1:0] pwdata,
  output logic [tmas_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  output tmas_pkg::cfg_t                 cfg_o
);
  import tmas_pkg::*;

  logic [PRESS_W-1:0] pressure_limit_q;
  logic [GAP_W-1:0]   gap_limit_q;
  logic               wr_en;
  reg_idx_e           reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = reg_idx_e'(paddr[REG_ADDR_LSB]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressure_limit_q <= PRESSURE_LIMIT_RST;
      gap_limit_q      <= GAP_LIMIT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PRESSURE_LIMIT: pressure_limit_q <= pwdata[PRESS_W-1:0];
        REG_GAP_LIMIT:      gap_limit_q      <= pwdata[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PRESSURE_LIMIT: prdata = APB_DATA_W'(pressure_limit_q);
      REG_GAP_LIMIT:      prdata = APB_DATA_W'(gap_limit_q);
      default:            prdata = '0;
    endcase
  end

  assign cfg_o.pressure_limit = pressure_limit_q;
  assign cfg_o.gap_limit_ms   = gap_limit_q;

endmodule

@@ design/tmas_move_scale.sv @@
// Scales one signed move delta by the rate gain: round half away from zero,
// saturate to 16 bits. Depends on tmas_pkg.
module tmas_move_scale (
  input  logic signed [tmas_pkg::MOVE_W-1:0] delta_i,
  input  logic        [tmas_pkg::GAIN_W-1:0] gain_i,
  output logic signed [tmas_pkg::MOVE_W-1:0] move_o
);
  import tmas_pkg::*;

  localparam int unsigned MAG_W  = MOVE_W + 1;
  localparam int unsigned PROD_W = MAG_W + GAIN_W;
  localparam int unsigned Q_W    = PROD_W - GAIN_FRAC_BITS;
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (GAIN_FRAC_BITS - 1);
  localparam logic [Q_W-1:0]    NEG_LIMIT  = Q_W'(32768);
  localparam logic [Q_W-1:0]    POS_LIMIT  = Q_W'(32767);

  logic              neg;
  logic [MAG_W-1:0]  mag;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] rounded;
  logic [Q_W-1:0]    q;
  logic [Q_W-1:0]    q_sat;

  always_comb begin
    neg     = delta_i[MOVE_W-1];
    mag     = neg ? (MAG_W'(0) - {delta_i[MOVE_W-1], delta_i}) : {1'b0, delta_i};
    prod    = PROD_W'(mag) * PROD_W'(gain_i);
    rounded = prod + ROUND_HALF;
    q       = rounded[PROD_W-1:GAIN_FRAC_BITS];
    if (neg) begin
      q_sat  = (q > NEG_LIMIT) ? NEG_LIMIT : q;
      move_o = $signed(MOVE_W'(0) - q_sat[MOVE_W-1:0]);
    end else begin
      q_sat  = (q > POS_LIMIT) ? POS_LIMIT : q;
      move_o = $signed(q_sat[MOVE_W-1:0]);
    end
  end

endmodule

@@ design/tmas_motion.sv @@
// Tracking state and single-pass decision logic: pointer move for one finger,
// scroll for two. Depends on tmas_pkg and tmas_move_scale.
module tmas_motion (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tmas_pkg::touch_item_t item_i,
  input  logic                  fire_i,
  input  tmas_pkg::cfg_t        cfg_i,
  output tmas_pkg::result_t     result_o
);
  import tmas_pkg::*;

  // x / 5 == (x * 0xCCCD) >> 18 for any 16-bit magnitude
  localparam int unsigned         DY_MAG_W    = COORD_W + 1;
  localparam logic [15:0]         DIV5_RECIP  = 16'hCCCD;
  localparam int unsigned         DIV5_SHIFT  = 18;
  localparam int unsigned         DIV_PROD_W  = DY_MAG_W + 16;
  localparam int unsigned         QUOT_W      = DIV_PROD_W - DIV5_SHIFT;

  logic [COORD_W-1:0] prev_x_q, prev_y_q, prev_mean_y_q;
  logic [TIME_W-1:0]  prev_time_q;
  logic               single_valid_q, dual_valid_q;

  logic                     single_hit, dual_hit;
  logic                     use_prev_pos, use_prev_mean;
  logic [COORD_W-1:0]       sel_x, sel_y;
  logic [TIME_W-1:0]        dt_raw, dt;
  logic [GAP_W-1:0]         lim;
  logic                     move_ok;
  logic [GAIN_W-1:0]        gain;
  logic signed [MOVE_W-1:0] dx, dy_move, move_x, move_y;

  logic [COORD_W-1:0]    ya, yb, mean_y, dy;
  logic [COORD_W:0]      y_sum;
  logic                  dy_neg;
  logic [DY_MAG_W-1:0]   dy_mag;
  logic [DIV_PROD_W-1:0] quot_prod;
  logic [QUOT_W-1:0]     quot;
  logic [MOVE_W-1:0]     scroll_amt;
  logic                  scroll_ok;

  always_comb begin
    single_hit   = item_i.first_touch & ~item_i.second_touch;
    dual_hit     = item_i.first_touch & item_i.second_touch;

    // heavy press: position is unreliable, hold the last one
    use_prev_pos = (item_i.first_pressure > cfg_i.pressure_limit) & single_valid_q;
    sel_x        = use_prev_pos ? prev_x_q : item_i.first_x;
    sel_y        = use_prev_pos ? prev_y_q : item_i.first_y;

    dt_raw  = item_i.time_ms - prev_time_q;
    dt      = (dt_raw == '0) ? TIME_W'(1) : dt_raw;
    lim     = (cfg_i.gap_limit_ms > GAP_W'(MAX_GAP_MS)) ? GAP_W'(MAX_GAP_MS)
                                                        : cfg_i.gap_limit_ms;
    move_ok = single_valid_q & (dt < TIME_W'(lim));
    gain    = gain_lookup(dt[GAP_IDX_W-1:0]);
    dx      = $signed(sel_x - prev_x_q);
    dy_move = $signed(sel_y - prev_y_q);

    use_prev_mean = (item_i.first_pressure > cfg_i.pressure_limit) |
                    (item_i.second_pressure > cfg_i.pressure_limit);
    ya        = use_prev_mean ? prev_mean_y_q : item_i.first_y;
    yb        = use_prev_mean ? prev_mean_y_q : item_i.second_y;
    y_sum     = {1'b0, ya} + {1'b0, yb};
    mean_y    = y_sum[COORD_W:1];
    dy        = mean_y - prev_mean_y_q;
    dy_neg    = dy[COORD_W-1];
    dy_mag    = dy_neg ? (DY_MAG_W'(0) - {dy[COORD_W-1], dy}) : {1'b0, dy};
    quot_prod = DIV_PROD_W'(dy_mag) * DIV_PROD_W'(DIV5_RECIP);
    quot      = quot_prod[DIV_PROD_W-1:DIV5_SHIFT];
    // scroll runs opposite to finger motion
    scroll_amt = dy_neg ? MOVE_W'(quot) : (MOVE_W'(0) - MOVE_W'(quot));
    scroll_ok  = dual_valid_q & (quot != '0);
  end

  tmas_move_scale u_scale_x (
    .delta_i (dx),
    .gain_i  (gain),
    .move_o  (move_x)
  );

  tmas_move_scale u_scale_y (
    .delta_i (dy_move),
    .gain_i  (gain),
    .move_o  (move_y)
  );

  always_comb begin
    result_o = '0;
    if (single_hit) begin
      result_o.valid      = move_ok;
      result_o.kind       = KIND_MOVE;
      result_o.horizontal = move_x;
      result_o.vertical   = move_y;
    end else if (dual_hit) begin
      result_o.valid      = scroll_ok;
      result_o.kind       = KIND_SCROLL;
      result_o.horizontal = '0;
      result_o.vertical   = $signed(scroll_amt);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q       <= '0;
      prev_y_q       <= '0;
      prev_time_q    <= '0;
      prev_mean_y_q  <= '0;
      single_valid_q <= 1'b0;
      dual_valid_q   <= 1'b0;
    end else if (fire_i) begin
      if (single_hit) begin
        prev_x_q       <= sel_x;
        prev_y_q       <= sel_y;
        prev_time_q    <= item_i.time_ms;
        single_valid_q <= 1'b1;
        dual_valid_q   <= 1'b0;
      end else if (dual_hit) begin
        prev_mean_y_q  <= mean_y;
        dual_valid_q   <= 1'b1;
        single_valid_q <= 1'b0;
      end else begin
        single_valid_q <= 1'b0;
        dual_valid_q   <= 1'b0;
      end
    end
  end

endmodule

@@ design/touch_motion_accel_scroll_unit.sv @@
// Touch motion unit: takes one touch report beat per clock and returns at most
// one pointer-move or scroll beat. Throughput is one report per cycle, set by the
// single-pass datapath between the input register and the result register (gain
// ROM lookup plus two 17x31 multiplies, and a reciprocal multiply for scroll).
// A result beat is registered twice: the input register loads on the accepting
// edge and the result register when stage 1 hands the item over.
// The input stalls only while both registers are full and out_ready_i is low.
// A report that causes no result is simply absorbed. There is no clearing pass
// after reset.
module touch_motion_accel_scroll_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tmas_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [tmas_pkg::APB_DATA_W-1:0] pwdata,
  output logic [tmas_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            first_touch_i,
  input  logic                            second_touch_i,
  input  logic [tmas_pkg::COORD_W-1:0]    first_x_i,
  input  logic [tmas_pkg::COORD_W-1:0]    first_y_i,
  input  logic [tmas_pkg::PRESS_W-1:0]    first_pressure_i,
  input  logic [tmas_pkg::COORD_W-1:0]    second_y_i,
  input  logic [tmas_pkg::PRESS_W-1:0]    second_pressure_i,
  input  logic [tmas_pkg::TIME_W-1:0]     time_ms_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            report_kind_o,
  output logic signed [tmas_pkg::MOVE_W-1:0] horizontal_o,
  output logic signed [tmas_pkg::MOVE_W-1:0] vertical_o
);
  import tmas_pkg::*;

  cfg_t        cfg;
  touch_item_t item_d, item_q;
  logic        s1_valid_q;
  logic        s1_fire;
  logic        in_accept;
  result_t     res;

  logic                     out_valid_q;
  report_kind_e             kind_q;
  logic signed [MOVE_W-1:0] horizontal_q, vertical_q;

  tmas_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign item_d.first_touch     = first_touch_i;
  assign item_d.second_touch    = second_touch_i;
  assign item_d.first_x         = first_x_i;
  assign item_d.first_y         = first_y_i;
  assign item_d.first_pressure  = first_pressure_i;
  assign item_d.second_y        = second_y_i;
  assign item_d.second_pressure = second_pressure_i;
  assign item_d.time_ms         = time_ms_i;

  // stage 1 moves on whenever the result register is free or being drained
  assign s1_fire    = s1_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~s1_valid_q | s1_fire;
  assign in_accept  = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= item_d;
    end
  end

  tmas_motion u_motion (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_q),
    .fire_i   (s1_fire),
    .cfg_i    (cfg),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= res.valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && res.valid) begin
      kind_q       <= res.kind;
      horizontal_q <= res.horizontal;
      vertical_q   <= res.vertical;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign report_kind_o = kind_q;
  assign horizontal_o  = horizontal_q;
  assign vertical_o    = vertical_q;

  // a result beat only appears after stage 1 hands over an item
  a_result_from_fire : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_fire))
    else $error("result valid rose without a stage-1 handover");

  // scroll beats carry no horizontal part and never a zero amount
  a_scroll_shape : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q == KIND_SCROLL) |-> (horizontal_q == '0 && vertical_q != '0))
    else $error("malformed scroll beat");

  // a stalled input beat means stage 1 is occupied and stays so
  a_stall_holds_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_ready_o) |=> s1_valid_q)
    else $error("stage 1 dropped an item while input was stalled");

endmodule
